### hdl/mvcs_pkg.sv
package mvcs_pkg;

    localparam int NODE_COUNT_DEF = 4;

    localparam int FIRST_NODE_W = 6;
    localparam int MAX_MAG_W    = 31;
    localparam int TIMEOUT_W    = 16;
    localparam int PERIOD_W     = 10;
    localparam int CFG_DATA_W   = 31;
    localparam int CFG_ADDR_W   = 2;
    localparam int CMD_W        = 5;
    localparam int FRAME_ID_W   = 11;

    localparam logic [FIRST_NODE_W-1:0] FIRST_NODE_RST  = 6'd10;
    localparam logic [MAX_MAG_W-1:0]    MAX_MAG_RST     = 31'h4120_0000;
    localparam logic [TIMEOUT_W-1:0]    TIMEOUT_RST     = 16'd500;
    localparam logic [PERIOD_W-1:0]     SEND_PERIOD_RST = 10'd10;

    localparam logic [MAX_MAG_W-1:0] FLOAT_INF_MAG = 31'h7F80_0000;
    localparam logic [TIMEOUT_W-1:0] IDLE_MAX      = 16'hFFFF;

    localparam logic [CMD_W-1:0] CMD_AXIS = 5'h07;
    localparam logic [CMD_W-1:0] CMD_MODE = 5'h0B;
    localparam logic [CMD_W-1:0] CMD_VEL  = 5'h0D;

    localparam logic [31:0] AXIS_IDLE   = 32'd1;
    localparam logic [31:0] AXIS_CLOSED = 32'd8;
    localparam logic [31:0] MODE_VEL    = 32'd2;
    localparam logic [31:0] INPUT_RAMP  = 32'd2;

    typedef enum logic [1:0] {
        FUNC_SETVEL = 2'd0,
        FUNC_TICK   = 2'd1,
        FUNC_START  = 2'd2,
        FUNC_STOP   = 2'd3
    } func_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_FIRST_NODE  = 2'd0,
        REG_MAX_MAG     = 2'd1,
        REG_TIMEOUT     = 2'd2,
        REG_SEND_PERIOD = 2'd3
    } cfg_reg_t;

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } state_t;

    function automatic logic [31:0] clamp_vel(input logic [31:0] v,
                                              input logic [MAX_MAG_W-1:0] limit);
        logic [MAX_MAG_W-1:0] mag;
        mag = v[30:0];
        if (mag > FLOAT_INF_MAG) begin
            return v;
        end else if (mag > limit) begin
            return {v[31], limit};
        end
        return v;
    endfunction

endpackage

### hdl/motor_velocity_command_sequencer.sv
// Motor velocity command sequencer.
// Input channel (s_valid/s_ready) carries one event per transfer: set velocity,
// 1 ms tick, start or stop. Result channel (m_valid/m_ready) carries CAN frames
// with an 11-bit id and two payload words; m_last marks the final frame of an event.
// Set velocity produces no frame. Start and stop produce two frames per node; a
// tick that ends a send period produces one velocity frame per enabled node. A
// node walker emits at most one frame per cycle while the output is free, and a
// tick round also steps over each disabled node below the last enabled one. The
// first frame reaches the output register only after the transfer has moved the
// walker from idle into its walk state.
// s_ready is high only while the walker is idle; the output register lets a new
// event be taken while the final frame still waits. When the receiver stalls the
// walker holds its place and the frame stays on the output.
// The configuration port writes one register per cycle with cfg_wr_en; the user must
// use it only while the block is idle (not enforced). Synchronous reset restores register
// defaults, zeroes all stored velocities, disables all nodes and clears both counters.
module motor_velocity_command_sequencer #(
    parameter int NODE_COUNT = mvcs_pkg::NODE_COUNT_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [mvcs_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [mvcs_pkg::CFG_DATA_W-1:0]      cfg_wr_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [1:0]                           s_func,
    input  logic [7:0]                           s_node,
    input  logic [31:0]                          s_velocity_bits,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [mvcs_pkg::FRAME_ID_W-1:0]      m_frame_id,
    output logic [31:0]                          m_payload_low,
    output logic [31:0]                          m_payload_high,
    output logic                                 m_last
);
    import mvcs_pkg::*;

    localparam int SLOT_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam logic [SLOT_W-1:0] SLOT_LAST  = SLOT_W'(NODE_COUNT - 1);
    localparam logic [7:0]        NODE_COUNT_B = 8'(NODE_COUNT);

    logic [FIRST_NODE_W-1:0] first_node_reg;
    logic [MAX_MAG_W-1:0]    max_mag_reg;
    logic [TIMEOUT_W-1:0]    timeout_reg;
    logic [PERIOD_W-1:0]     send_period_reg;

    state_t state_reg, state_next;
    func_t  op_reg, op_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic phase_reg, phase_next;

    logic [31:0]         velocity_store_reg [NODE_COUNT];
    logic [31:0]         velocity_store_next [NODE_COUNT];
    logic [NODE_COUNT-1:0] enabled_reg, enabled_next;
    logic [TIMEOUT_W-1:0]  idle_count_reg, idle_count_next;
    logic [PERIOD_W-1:0]   send_count_reg, send_count_next;

    logic                  m_valid_reg, m_valid_next;
    logic [FRAME_ID_W-1:0] m_frame_id_reg, m_frame_id_next;
    logic [31:0]           m_payload_low_reg, m_payload_low_next;
    logic [31:0]           m_payload_high_reg, m_payload_high_next;
    logic                  m_last_reg, m_last_next;

    logic                    s_accept;
    logic                    out_free;
    func_t                   in_func;
    logic [7:0]              node_diff;
    logic                    node_in_range;
    logic [TIMEOUT_W-1:0]    idle_inc;
    logic [PERIOD_W-1:0]     send_inc;
    logic                    round_due;
    logic                    more_enabled;
    logic                    frame_last;
    logic                    frame_load;
    logic [CMD_W-1:0]        frame_cmd;
    logic [31:0]             frame_low;
    logic [31:0]             frame_high;
    logic [31:0]             clamp_in;
    logic [FIRST_NODE_W-1:0] frame_node;

    assign s_ready        = (state_reg == ST_IDLE);
    assign s_accept       = s_valid && s_ready;
    assign out_free       = !m_valid_reg || m_ready;
    assign in_func        = func_t'(s_func);
    assign node_diff      = s_node - {2'b00, first_node_reg};
    assign node_in_range  = (s_node >= {2'b00, first_node_reg}) && (node_diff < NODE_COUNT_B);
    assign idle_inc       = (idle_count_reg == IDLE_MAX) ? idle_count_reg
                                                         : idle_count_reg + 1'b1;
    assign send_inc       = send_count_reg + 1'b1;
    assign round_due      = (send_inc >= send_period_reg);
    assign frame_node     = first_node_reg + FIRST_NODE_W'(slot_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_node_reg  <= FIRST_NODE_RST;
            max_mag_reg     <= MAX_MAG_RST;
            timeout_reg     <= TIMEOUT_RST;
            send_period_reg <= SEND_PERIOD_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_FIRST_NODE:  first_node_reg  <= cfg_wr_data[FIRST_NODE_W-1:0];
                REG_MAX_MAG:     max_mag_reg     <= cfg_wr_data[MAX_MAG_W-1:0];
                REG_TIMEOUT:     timeout_reg     <= cfg_wr_data[TIMEOUT_W-1:0];
                REG_SEND_PERIOD: send_period_reg <= cfg_wr_data[PERIOD_W-1:0];
                default:         first_node_reg  <= first_node_reg;
            endcase
        end
    end

    always_comb begin
        more_enabled = 1'b0;
        for (int j = 0; j < NODE_COUNT; j++) begin
            if (SLOT_W'(j) > slot_reg) begin
                more_enabled = more_enabled | enabled_reg[j];
            end
        end
    end

    always_comb begin
        clamp_in   = '0;
        frame_high = '0;
        unique case (op_reg)
            FUNC_TICK: begin
                clamp_in  = velocity_store_reg[slot_reg];
                frame_cmd = CMD_VEL;
                frame_low = clamp_vel(clamp_in, max_mag_reg);
            end
            FUNC_START: begin
                frame_cmd  = phase_reg ? CMD_AXIS : CMD_MODE;
                frame_low  = phase_reg ? AXIS_CLOSED : MODE_VEL;
                frame_high = phase_reg ? 32'd0 : INPUT_RAMP;
            end
            FUNC_STOP: begin
                frame_cmd = phase_reg ? CMD_AXIS : CMD_VEL;
                frame_low = phase_reg ? AXIS_IDLE : clamp_vel(clamp_in, max_mag_reg);
            end
            default: begin
                frame_cmd = CMD_VEL;
                frame_low = '0;
            end
        endcase
        frame_last = (op_reg == FUNC_TICK) ? !more_enabled
                                           : (phase_reg && (slot_reg == SLOT_LAST));
    end

    always_comb begin
        state_next          = state_reg;
        op_next             = op_reg;
        slot_next           = slot_reg;
        phase_next          = phase_reg;
        velocity_store_next = velocity_store_reg;
        enabled_next        = enabled_reg;
        idle_count_next     = idle_count_reg;
        send_count_next     = send_count_reg;
        m_valid_next        = m_valid_reg && !m_ready;
        m_frame_id_next     = m_frame_id_reg;
        m_payload_low_next  = m_payload_low_reg;
        m_payload_high_next = m_payload_high_reg;
        m_last_next         = m_last_reg;
        frame_load          = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    op_next    = in_func;
                    slot_next  = '0;
                    phase_next = 1'b0;
                    unique case (in_func)
                        FUNC_SETVEL: begin
                            if (node_in_range) begin
                                velocity_store_next[node_diff[SLOT_W-1:0]] = s_velocity_bits;
                                idle_count_next = '0;
                            end
                        end
                        FUNC_TICK: begin
                            idle_count_next = idle_inc;
                            if (round_due) begin
                                send_count_next = '0;
                                if (idle_inc > timeout_reg) begin
                                    for (int j = 0; j < NODE_COUNT; j++) begin
                                        velocity_store_next[j] = '0;
                                    end
                                end
                                if (|enabled_reg) begin
                                    state_next = ST_WALK;
                                end
                            end else begin
                                send_count_next = send_inc;
                            end
                        end
                        FUNC_START: begin
                            enabled_next    = '1;
                            idle_count_next = '0;
                            state_next      = ST_WALK;
                        end
                        FUNC_STOP: begin
                            enabled_next = '0;
                            state_next   = ST_WALK;
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_WALK: begin
                if ((op_reg == FUNC_TICK) && !enabled_reg[slot_reg]) begin
                    slot_next = slot_reg + 1'b1;
                end else if (out_free) begin
                    frame_load          = 1'b1;
                    m_valid_next        = 1'b1;
                    m_frame_id_next     = {frame_node, frame_cmd};
                    m_payload_low_next  = frame_low;
                    m_payload_high_next = frame_high;
                    m_last_next         = frame_last;
                    if (frame_last) begin
                        state_next = ST_IDLE;
                    end else if ((op_reg == FUNC_TICK) || phase_reg) begin
                        slot_next  = slot_reg + 1'b1;
                        phase_next = 1'b0;
                    end else begin
                        phase_next = 1'b1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            op_reg         <= FUNC_SETVEL;
            slot_reg       <= '0;
            phase_reg      <= 1'b0;
            enabled_reg    <= '0;
            idle_count_reg <= '0;
            send_count_reg <= '0;
            m_valid_reg    <= 1'b0;
            for (int j = 0; j < NODE_COUNT; j++) begin
                velocity_store_reg[j] <= '0;
            end
        end else begin
            state_reg          <= state_next;
            op_reg             <= op_next;
            slot_reg           <= slot_next;
            phase_reg          <= phase_next;
            enabled_reg        <= enabled_next;
            idle_count_reg     <= idle_count_next;
            send_count_reg     <= send_count_next;
            m_valid_reg        <= m_valid_next;
            velocity_store_reg <= velocity_store_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_frame_id_reg     <= m_frame_id_next;
        m_payload_low_reg  <= m_payload_low_next;
        m_payload_high_reg <= m_payload_high_next;
        m_last_reg         <= m_last_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_frame_id     = m_frame_id_reg;
    assign m_payload_low  = m_payload_low_reg;
    assign m_payload_high = m_payload_high_reg;
    assign m_last         = m_last_reg;

    a_setvel_no_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && (in_func == FUNC_SETVEL)) |=> (state_reg == ST_IDLE))
        else $error("Set velocity started a frame walk.");

    a_start_enables: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && (in_func == FUNC_START)) |=> (&enabled_reg))
        else $error("Start did not enable every node.");

    a_stop_disables: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && (in_func == FUNC_STOP)) |=> (enabled_reg == '0))
        else $error("Stop left a node enabled.");

    a_last_ends_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        (frame_load && frame_last) |=> (state_reg == ST_IDLE) && m_valid_reg && m_last_reg)
        else $error("Final frame did not end the walk.");

    a_idle_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (idle_count_reg != $past(idle_count_reg))
            |-> ((idle_count_reg == '0) || (idle_count_reg == $past(idle_count_reg) + 1'b1)))
        else $error("Idle count moved by more than one step.");

endmodule
